/* rtl/core/nearest_vertex_linear_search_defines.svh */
// ----------------------------------------------------------------------------
// nearest vertex search assertion macros
// shared property shorthands, clocked on aclk with synchronous reset aresetn
// ----------------------------------------------------------------------------
`ifndef NEAREST_VERTEX_LINEAR_SEARCH_DEFINES_SVH
`define NEAREST_VERTEX_LINEAR_SEARCH_DEFINES_SVH

// same-cycle implication
`define NVLS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nvls same-cycle check failed");

// next-cycle implication
`define NVLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nvls next-cycle check failed");

`endif

/* rtl/core/nvls_pkg.sv */
// ----------------------------------------------------------------------------
// nvls_pkg
// shared types, constants and helpers of the nearest vertex search block
// ----------------------------------------------------------------------------
package nvls_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 24;
    localparam int IDX_BITS     = $clog2(MAX_VERTICES);
    localparam int FIELD_IDX_BITS = 8;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int SQ_BITS      = 2 * DIFF_BITS;
    localparam int SUM_BITS     = SQ_BITS + 2;
    localparam int DIST_BITS    = 52;
    localparam int DIMS_BITS    = 2;
    localparam int COUNT_BITS   = 9;

    // action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // register index codes (byte address bit 2)
    localparam logic REG_DIMS  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef struct packed {
        logic                          action;
        logic [FIELD_IDX_BITS-1:0]     vertex_index;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
        logic signed [COORD_BITS-1:0]  coord_z;
    } in_payload_t;

    typedef struct packed {
        logic                       is_query_answer;
        logic [FIELD_IDX_BITS-1:0]  nearest_index;
        logic [DIST_BITS-1:0]       squared_distance;
    } out_payload_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } vertex_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } nvls_state_t;

    // controller to datapath
    typedef struct packed {
        logic                capture;
        logic                load_wr;
        logic                clear_best;
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_addr;
        logic                push_result;
        logic                push_query;
    } nvls_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } nvls_stat_t;

    // last slot scanned: zero count means one slot, large counts saturate
    function automatic logic [IDX_BITS-1:0] last_slot(input logic [COUNT_BITS-1:0] cnt);
        logic [IDX_BITS-1:0] r;
        if (cnt == '0) begin
            r = '0;
        end else if (int'(cnt) >= MAX_VERTICES) begin
            r = IDX_BITS'(MAX_VERTICES - 1);
        end else begin
            r = IDX_BITS'(cnt - COUNT_BITS'(1));
        end
        return r;
    endfunction

endpackage

/* rtl/core/nvls_ctrl.sv */
// ----------------------------------------------------------------------------
// nvls_ctrl
// sequencer: accepts transactions, walks the scan address, launches results
// ----------------------------------------------------------------------------
module nvls_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         in_action,
    input  logic [nvls_pkg::IDX_BITS-1:0] last_idx,
    input  nvls_pkg::nvls_stat_t         stat,
    output nvls_pkg::nvls_cmd_t          cmd
);
    import nvls_pkg::*;

    nvls_state_t         state_reg, state_next;
    logic [IDX_BITS-1:0] addr_reg, addr_next;
    logic                query_reg, query_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
            query_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            query_reg <= query_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        query_next = query_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.rd_addr = addr_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (in_action == ACT_LOAD) begin
                        cmd.load_wr = 1'b1;
                        query_next  = 1'b0;
                        state_next  = ST_RESULT;
                    end else begin
                        cmd.clear_best = 1'b1;
                        query_next     = 1'b1;
                        addr_next      = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (addr_reg == last_idx) begin
                    state_next = ST_RESULT;
                end else begin
                    addr_next = addr_reg + IDX_BITS'(1);
                end
            end
            ST_RESULT: begin
                if (!stat.pipe_busy && stat.out_free) begin
                    cmd.push_result = 1'b1;
                    cmd.push_query  = query_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/nvls_datapath.sv */
// ----------------------------------------------------------------------------
// nvls_datapath
// vertex memory, distance pipeline, running minimum and output register
// ----------------------------------------------------------------------------
module nvls_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  nvls_pkg::in_payload_t         in_data,
    input  logic [nvls_pkg::DIMS_BITS-1:0] dims,
    input  nvls_pkg::nvls_cmd_t           cmd,
    output nvls_pkg::nvls_stat_t          stat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output nvls_pkg::out_payload_t        m_payload
);
    import nvls_pkg::*;

    // vertex memory, contents undefined until loaded
    vertex_t mem [MAX_VERTICES];

    vertex_t point_reg;
    vertex_t rd_data_reg;
    logic    rd_valid_reg;
    logic [IDX_BITS-1:0] rd_idx_reg;

    logic signed [DIFF_BITS-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DIFF_BITS-1:0] dx_next, dy_next, dz_next;
    logic                d_valid_reg;
    logic [IDX_BITS-1:0] d_idx_reg;

    logic signed [SQ_BITS-1:0] px, py, pz;
    logic [SQ_BITS-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic                sq_valid_reg;
    logic [IDX_BITS-1:0] sq_idx_reg;

    logic [SUM_BITS-1:0] sum_reg;
    logic                sum_valid_reg;
    logic [IDX_BITS-1:0] sum_idx_reg;

    logic [SUM_BITS-1:0] best_dist_reg;
    logic [IDX_BITS-1:0] best_idx_reg;
    logic                best_found_reg;

    logic         m_valid_reg;
    out_payload_t m_payload_reg;
    logic         out_free;

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && (int'(in_data.vertex_index) < MAX_VERTICES)) begin
            mem[IDX_BITS'(in_data.vertex_index)] <= '{x: in_data.coord_x,
                                                      y: in_data.coord_y,
                                                      z: in_data.coord_z};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    // per-axis differences, unused axes forced to zero
    always_comb begin
        dx_next = DIFF_BITS'(rd_data_reg.x) - DIFF_BITS'(point_reg.x);
        dy_next = DIFF_BITS'(rd_data_reg.y) - DIFF_BITS'(point_reg.y);
        dz_next = DIFF_BITS'(rd_data_reg.z) - DIFF_BITS'(point_reg.z);
        if (dims < DIMS_BITS'(2)) begin
            dy_next = '0;
        end
        if (dims != DIMS_BITS'(3)) begin
            dz_next = '0;
        end
    end

    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    // payload stages
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            point_reg <= '{x: in_data.coord_x, y: in_data.coord_y, z: in_data.coord_z};
        end
        rd_idx_reg  <= cmd.rd_addr;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dz_reg      <= dz_next;
        d_idx_reg   <= rd_idx_reg;
        sqx_reg     <= $unsigned(px);
        sqy_reg     <= $unsigned(py);
        sqz_reg     <= $unsigned(pz);
        sq_idx_reg  <= d_idx_reg;
        sum_reg     <= SUM_BITS'(sqx_reg) + SUM_BITS'(sqy_reg) + SUM_BITS'(sqz_reg);
        sum_idx_reg <= sq_idx_reg;
    end

    // stage valids, running minimum and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            d_valid_reg    <= 1'b0;
            sq_valid_reg   <= 1'b0;
            sum_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            rd_valid_reg  <= cmd.rd_en;
            d_valid_reg   <= rd_valid_reg;
            sq_valid_reg  <= d_valid_reg;
            sum_valid_reg <= sq_valid_reg;
            if (cmd.clear_best) begin
                best_found_reg <= 1'b0;
            end else if (sum_valid_reg) begin
                best_found_reg <= 1'b1;
            end
            if (cmd.push_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // strict less-than keeps the lowest index on ties
    always_ff @(posedge aclk) begin
        if (sum_valid_reg && (!best_found_reg || (sum_reg < best_dist_reg))) begin
            best_dist_reg <= sum_reg;
            best_idx_reg  <= sum_idx_reg;
        end
        if (cmd.push_result) begin
            if (cmd.push_query) begin
                m_payload_reg.is_query_answer  <= 1'b1;
                m_payload_reg.nearest_index    <= FIELD_IDX_BITS'(best_idx_reg);
                m_payload_reg.squared_distance <= DIST_BITS'(best_dist_reg);
            end else begin
                m_payload_reg <= '0;
            end
        end
    end

    assign out_free       = !m_valid_reg || m_ready;
    assign stat.out_free  = out_free;
    assign stat.pipe_busy = rd_valid_reg || d_valid_reg || sq_valid_reg || sum_valid_reg;
    assign m_valid        = m_valid_reg;
    assign m_payload      = m_payload_reg;

endmodule

/* rtl/core/nearest_vertex_linear_search.sv */
// ----------------------------------------------------------------------------
// nearest_vertex_linear_search
// brute-force nearest vertex search over a 256-entry table of 3-d vertices.
// s_ channel: a load transaction writes one vertex, a query transaction
// carries a point; m_ channel returns one result transaction per input:
// an all-zero acknowledge for a load, index and squared distance for a query.
// a query scans the table through the single read port of the vertex memory
// (one vertex a cycle, through a 4-stage distance pipeline and a running
// minimum compare). one item is in work at a time; the next is accepted as
// soon as the previous result sits in the output register, even if it is
// still stalled. a stalled m_ready holds the result and blocks only the
// launch of the next. reset clears control and registers (dimension_count 3,
// vertex_count 1); table contents are undefined until loaded. registers sit
// on an apb-style port at byte addresses 0 and 4; the user must see that they
// are written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "nearest_vertex_linear_search_defines.svh"

module nearest_vertex_linear_search (
    input  logic                    aclk,
    input  logic                    aresetn,
    // input transaction channel
    input  logic                    s_valid,
    output logic                    s_ready,
    input  nvls_pkg::in_payload_t   s_payload,
    // result transaction channel
    output logic                    m_valid,
    input  logic                    m_ready,
    output nvls_pkg::out_payload_t  m_payload,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import nvls_pkg::*;

    logic [DIMS_BITS-1:0]  dims_reg, dims_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  cfg_wr;
    logic [IDX_BITS-1:0]   last_idx;

    nvls_cmd_t  cmd;
    nvls_stat_t stat;

    // config write strobe on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        dims_next  = dims_reg;
        count_next = count_reg;
        if (cfg_wr) begin
            case (paddr[2])
                REG_DIMS:  dims_next  = pwdata[DIMS_BITS-1:0];
                REG_COUNT: count_next = pwdata[COUNT_BITS-1:0];
                default:   dims_next  = dims_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg  <= DIMS_BITS'(3);
            count_reg <= COUNT_BITS'(1);
        end else begin
            dims_reg  <= dims_next;
            count_reg <= count_next;
        end
    end

    // read-back mux
    always_comb begin
        case (paddr[2])
            REG_DIMS:  prdata = 32'(dims_reg);
            REG_COUNT: prdata = 32'(count_reg);
            default:   prdata = '0;
        endcase
    end

    // zero count scans slot 0, counts past the table saturate
    assign last_idx = last_slot(count_reg);

    nvls_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .in_action (s_payload.action),
        .last_idx  (last_idx),
        .stat      (stat),
        .cmd       (cmd)
    );

    nvls_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_payload),
        .dims      (dims_reg),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // an accepted transaction closes the input until its result is launched
    `NVLS_ASSERT_NEXT(a_accept_closes, s_valid && s_ready, !s_ready)
    // no new transaction while the memory is being scanned
    `NVLS_ASSERT_SAME(a_no_accept_in_scan, cmd.rd_en, !s_ready && !cmd.push_result)
    // a result is launched only from a drained pipeline into a free output
    `NVLS_ASSERT_SAME(a_push_when_free, cmd.push_result,
                      !stat.pipe_busy && stat.out_free)
    // a launched result shows up on the output next cycle
    `NVLS_ASSERT_NEXT(a_push_shows, cmd.push_result, m_valid)

endmodule
